FILE: design/dobf_pkg.sv
// ----------------------------------------------------------------------------
// dobf_pkg
// Shared codes, field widths and control types of the drop-oldest FIFO.
// ----------------------------------------------------------------------------
package dobf_pkg;

  // Operation codes carried on in_tuser
  localparam logic [1:0] OP_ENQ   = 2'd0;
  localparam logic [1:0] OP_DEQ   = 2'd1;
  localparam logic [1:0] OP_STOP  = 2'd2;
  localparam logic [1:0] OP_QUERY = 2'd3;

  // Result status codes carried on out_tuser
  localparam logic [1:0] STS_DONE      = 2'd0;
  localparam logic [1:0] STS_WOULDWAIT = 2'd1;
  localparam logic [1:0] STS_EMPTYSTOP = 2'd2;
  localparam logic [1:0] STS_REFUSED   = 2'd3;

  // Fixed field widths
  localparam int OP_W      = 2;
  localparam int STS_W     = 2;
  localparam int WORD_W    = 64;
  localparam int CAP_W     = 9;
  localparam int DEPTH_W   = 9;
  localparam int TOTAL_W   = 64;

  // Result tdata layout, lowest bit first
  localparam int OUT_FIELDS_W = WORD_W + 1 + DEPTH_W + 3 * TOTAL_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the accepted input item
    logic commit;  // apply the item and load the result register
  } dobf_cmd_t;

endpackage

FILE: design/dobf_ctrl.sv
// ----------------------------------------------------------------------------
// dobf_ctrl
// Two-state controller: takes an item, then commits it once the result
// register can take the outcome. Owns the result valid flag.
// ----------------------------------------------------------------------------
module dobf_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_tvalid,
  output logic              in_tready,
  output logic              out_tvalid,
  input  logic              out_tready,
  output dobf_pkg::dobf_cmd_t cmd
);
  import dobf_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_EXEC = 1'b1;

  logic state_r, state_nxt;
  logic out_valid_r, out_valid_nxt;
  logic accept;
  logic commit;

  assign in_tready  = (state_r == S_IDLE);
  assign accept     = in_tvalid && in_tready;
  // commit when the result register is empty or being drained this cycle
  assign commit     = (state_r == S_EXEC) && (!out_valid_r || out_tready);
  assign out_tvalid = out_valid_r;

  assign cmd.load   = accept;
  assign cmd.commit = commit;

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        if (commit) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // result valid flag
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

`ifndef SYNTH
  a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> (state_r == S_EXEC))
    else $error("accepted item did not enter execution");
  a_commit_gives_result: assert property (@(posedge clk) disable iff (!rst_n)
    commit |=> out_valid_r)
    else $error("committed item produced no result");
  a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EXEC) && !commit |=> (state_r == S_EXEC) && out_valid_r)
    else $error("stalled item left execution without a free result slot");
`endif

endmodule

FILE: design/dobf_datapath.sv
// ----------------------------------------------------------------------------
// dobf_datapath
// Entry memory, ring pointers, fill count, stop flag, wrapping totals,
// capacity register and the result register.
// ----------------------------------------------------------------------------
module dobf_datapath #(
  parameter int QUEUE_DEPTH   = 256,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  dobf_pkg::dobf_cmd_t              cmd,
  input  logic [dobf_pkg::OP_W-1:0]        in_op,
  input  logic [dobf_pkg::WORD_W-1:0]      in_payload,
  input  logic                             cfg_we,
  input  logic [dobf_pkg::CAP_W-1:0]       cfg_cap,
  output logic [dobf_pkg::STS_W-1:0]       out_status,
  output logic [dobf_pkg::OUT_TDATA_W-1:0] out_data
);
  import dobf_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
  localparam int CMP_W = (CNT_W > CAP_W) ? CNT_W : CAP_W;
  localparam logic [PTR_W-1:0] LAST_SLOT = PTR_W'(QUEUE_DEPTH - 1);
  localparam logic [CMP_W-1:0] DEPTH_MAX = CMP_W'(QUEUE_DEPTH);
  localparam logic [CMP_W-1:0] ONE_CMP   = CMP_W'(1);

  // entry memory: one write and one registered read port
  logic [PAYLOAD_WIDTH-1:0] entry_mem [QUEUE_DEPTH];
  logic [PAYLOAD_WIDTH-1:0] rd_data_r;
  logic                     mem_we;

  // captured item
  logic [OP_W-1:0]   op_r;
  logic [WORD_W-1:0] payload_r;

  // queue state
  logic [PTR_W-1:0]   head_r, head_nxt;
  logic [PTR_W-1:0]   tail_r, tail_nxt;
  logic [CNT_W-1:0]   fill_r, fill_nxt;
  logic               stopped_r, stopped_nxt;
  logic [TOTAL_W-1:0] enq_cnt_r, enq_cnt_nxt;
  logic [TOTAL_W-1:0] deq_cnt_r, deq_cnt_nxt;
  logic [TOTAL_W-1:0] drop_cnt_r, drop_cnt_nxt;
  logic [CAP_W-1:0]   cap_r;

  // result register
  logic [STS_W-1:0]   res_status_r, res_status_nxt;
  logic [WORD_W-1:0]  res_word_r, res_word_nxt;
  logic               res_drop_r, res_drop_nxt;
  logic [DEPTH_W-1:0] res_depth_r;

  // effective capacity and full test
  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;
  logic [CMP_W-1:0] fill_ext;
  logic [CMP_W-1:0] fill_nxt_ext;
  logic             at_cap;

  assign cap_ext  = CMP_W'(cap_r);
  assign fill_ext = CMP_W'(fill_r);
  always_comb begin
    if (cap_ext == '0) begin
      eff_cap = ONE_CMP;
    end else if (cap_ext > DEPTH_MAX) begin
      eff_cap = DEPTH_MAX;
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign at_cap = (fill_ext >= eff_cap) && (fill_r != '0);

  // item execution
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    fill_nxt       = fill_r;
    stopped_nxt    = stopped_r;
    enq_cnt_nxt    = enq_cnt_r;
    deq_cnt_nxt    = deq_cnt_r;
    drop_cnt_nxt   = drop_cnt_r;
    res_status_nxt = STS_DONE;
    res_word_nxt   = '0;
    res_drop_nxt   = 1'b0;
    mem_we         = 1'b0;
    if (cmd.commit) begin
      case (op_r)
        OP_ENQ: begin
          if (stopped_r) begin
            res_status_nxt = STS_REFUSED;
          end else begin
            mem_we      = 1'b1;
            tail_nxt    = (tail_r == LAST_SLOT) ? '0 : tail_r + 1'b1;
            enq_cnt_nxt = enq_cnt_r + 1'b1;
            if (at_cap) begin
              // oldest entry goes, depth stays
              head_nxt     = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
              drop_cnt_nxt = drop_cnt_r + 1'b1;
              res_drop_nxt = 1'b1;
            end else begin
              fill_nxt = fill_r + 1'b1;
            end
          end
        end
        OP_DEQ: begin
          if (fill_r == '0) begin
            res_status_nxt = stopped_r ? STS_EMPTYSTOP : STS_WOULDWAIT;
          end else begin
            res_word_nxt = WORD_W'(rd_data_r);
            head_nxt     = (head_r == LAST_SLOT) ? '0 : head_r + 1'b1;
            fill_nxt     = fill_r - 1'b1;
            deq_cnt_nxt  = deq_cnt_r + 1'b1;
          end
        end
        OP_STOP: begin
          stopped_nxt = 1'b1;
        end
        OP_QUERY: begin
          res_status_nxt = STS_DONE;
        end
        default: res_status_nxt = STS_DONE;
      endcase
    end
  end

  assign fill_nxt_ext = CMP_W'(fill_nxt);

  // memory ports; read tracks the head every cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[tail_r] <= payload_r[PAYLOAD_WIDTH-1:0];
    end
    rd_data_r <= entry_mem[head_r];
  end

  // item capture
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r      <= in_op;
      payload_r <= in_payload;
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      res_status_r <= res_status_nxt;
      res_word_r   <= res_word_nxt;
      res_drop_r   <= res_drop_nxt;
      res_depth_r  <= fill_nxt_ext[DEPTH_W-1:0];
    end
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r     <= '0;
      tail_r     <= '0;
      fill_r     <= '0;
      stopped_r  <= 1'b0;
      enq_cnt_r  <= '0;
      deq_cnt_r  <= '0;
      drop_cnt_r <= '0;
      cap_r      <= CAP_RESET;
    end else begin
      head_r     <= head_nxt;
      tail_r     <= tail_nxt;
      fill_r     <= fill_nxt;
      stopped_r  <= stopped_nxt;
      enq_cnt_r  <= enq_cnt_nxt;
      deq_cnt_r  <= deq_cnt_nxt;
      drop_cnt_r <= drop_cnt_nxt;
      if (cfg_we) begin
        cap_r <= cfg_cap;
      end
    end
  end

  // totals and stop flag are live registers; they only move on a commit
  assign out_status = res_status_r;
  assign out_data   = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), stopped_r, drop_cnt_r,
                       deq_cnt_r, enq_cnt_r, res_depth_r, res_drop_r, res_word_r};

`ifndef SYNTH
  a_fill_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    CMP_W'(fill_r) <= DEPTH_MAX)
    else $error("fill count beyond queue depth");
  a_stopped_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && stopped_r |=> $stable(tail_r) && $stable(enq_cnt_r))
    else $error("entry written after stop");
  a_drop_keeps_depth: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit && res_drop_nxt |=> $stable(fill_r))
    else $error("dropping enqueue changed the depth");
`endif

endmodule

FILE: design/drop_oldest_bounded_fifo_unit.sv
// ----------------------------------------------------------------------------
// drop_oldest_bounded_fifo_unit
// Bounded FIFO of payload words that drops the oldest entry on overflow.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one item per transfer; in_tuser is the operation (enqueue,
//           dequeue, stop, query), in_tdata the payload word.
//   out_* : one result per item, in order; out_tuser is the status,
//           out_tdata the dequeued word, drop flag, depth, the three
//           wrapping totals and the stopped flag.
//   cfg_* : writes the capacity register; always ready. Write only while
//           no item is in flight.
// An accepted item waits in the execution state and is committed once the
//   result register can take it; out_tvalid is high from the commit on.
// An item is taken only in the idle state, so the next one waits until the last
//   is committed; the registered read port of the entry memory sees the head after each commit.
// A new item is accepted while an earlier result waits in the output
// register; if out_tready stays low the next item waits in execution and
// in_tready stays low until the result register drains.
// Reset (rst_n low, synchronous): queue empty, running, totals zero,
//   capacity 256. Entry memory contents are not cleared; no slot is read
//   before it is written.
// ----------------------------------------------------------------------------
module drop_oldest_bounded_fifo_unit #(
  parameter int QUEUE_DEPTH   = 256,
  parameter int PAYLOAD_WIDTH = 64
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  input  logic [dobf_pkg::WORD_W-1:0]      in_tdata,   // [63:0] payload
  input  logic [dobf_pkg::OP_W-1:0]        in_tuser,   // [1:0] operation
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // [63:0] data_out, [64] dropped, [73:65] depth, [137:74] enqueued_total,
  // [201:138] dequeued_total, [265:202] dropped_total, [266] is_stopped,
  // [271:267] zero
  output logic [dobf_pkg::OUT_TDATA_W-1:0] out_tdata,
  output logic [dobf_pkg::STS_W-1:0]       out_tuser,  // [1:0] status
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [dobf_pkg::CAP_W-1:0]       cfg_data    // [8:0] capacity
);
  import dobf_pkg::*;

  dobf_cmd_t cmd;

  assign cfg_ready = 1'b1;

  dobf_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  dobf_datapath #(
    .QUEUE_DEPTH   (QUEUE_DEPTH),
    .PAYLOAD_WIDTH (PAYLOAD_WIDTH)
  ) u_datapath (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd        (cmd),
    .in_op      (in_tuser),
    .in_payload (in_tdata),
    .cfg_we     (cfg_valid && cfg_ready),
    .cfg_cap    (cfg_data),
    .out_status (out_tuser),
    .out_data   (out_tdata)
  );

endmodule

FILE: test/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the drop-oldest bounded FIFO unit. A scoreboard
// model tracks queue contents, capacity, stop flag and the three wrapping
// totals, and predicts one result per accepted item. Results are checked in
// order, field by field. Stimulus runs directed corner cases, a fill to full
// depth, random traffic over several capacities, then stop and drain.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import dobf_pkg::*;

  localparam int QDEPTH     = 256;
  localparam int IDLE_LIMIT = 5000;
  localparam int SETTLE     = 4;

  typedef struct {
    logic [STS_W-1:0]   status;
    logic [WORD_W-1:0]  word;
    logic               dropped;
    logic [DEPTH_W-1:0] depth;
    logic [TOTAL_W-1:0] enq_total;
    logic [TOTAL_W-1:0] deq_total;
    logic [TOTAL_W-1:0] drop_total;
    logic               stopped;
  } fifo_result_t;

  // DUT ports; the inputs driven by the bench are known from time zero
  logic                   clk       = 1'b0;
  logic                   rst_n     = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [WORD_W-1:0]      in_tdata  = '0;   // [63:0] payload
  logic [OP_W-1:0]        in_tuser  = OP_QUERY; // [1:0] operation
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  // [63:0] data_out, [64] dropped, [73:65] depth, [137:74] enqueued_total,
  // [201:138] dequeued_total, [265:202] dropped_total, [266] is_stopped
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [STS_W-1:0]       out_tuser;  // [1:0] status
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CAP_W-1:0]       cfg_data  = CAP_RESET; // [8:0] capacity

  // Scoreboard model of the queue
  logic [WORD_W-1:0]  model_mem [QDEPTH];
  logic [7:0]         model_head    = '0;
  logic [7:0]         model_tail    = '0;
  logic [DEPTH_W-1:0] model_fill    = '0;
  logic               model_stopped = 1'b0;
  logic [TOTAL_W-1:0] model_enq     = '0;
  logic [TOTAL_W-1:0] model_deq     = '0;
  logic [TOTAL_W-1:0] model_drop    = '0;
  logic [CAP_W-1:0]   model_cap     = CAP_RESET;

  fifo_result_t pending_results[$];

  // Traffic shaping and bookkeeping
  int burst_left   = 0;
  int gap_max      = 0;
  int ready_mode   = 0;
  int stall_left   = 0;
  int idle_cycles  = 0;
  int errors       = 0;
  int items_sent   = 0;
  int results_seen = 0;
  int cfg_writes   = 0;
  int peak_depth   = 0;

  always #5 clk = ~clk;

  drop_oldest_bounded_fifo_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_data   (cfg_data)
  );

  // Apply one item to the model and return the result it should produce
  function automatic fifo_result_t predict_fifo_result(logic [OP_W-1:0] op,
                                                       logic [WORD_W-1:0] payload);
    fifo_result_t r;
    int unsigned  limit;
    r = '{default: '0};
    limit = (model_cap == 0) ? 1 : ((model_cap > QDEPTH) ? QDEPTH : model_cap);
    case (op)
      OP_ENQ: begin
        if (model_stopped) begin
          r.status = STS_REFUSED;
        end else begin
          // full (or over a lowered capacity): discard the oldest first
          if (model_fill >= limit && model_fill != 0) begin
            model_head = model_head + 8'd1;
            model_fill = model_fill - 1'b1;
            model_drop = model_drop + 1'b1;
            r.dropped  = 1'b1;
          end
          model_mem[model_tail] = payload;
          model_tail = model_tail + 8'd1;
          model_fill = model_fill + 1'b1;
          model_enq  = model_enq + 1'b1;
        end
      end
      OP_DEQ: begin
        if (model_fill == 0) begin
          r.status = model_stopped ? STS_EMPTYSTOP : STS_WOULDWAIT;
        end else begin
          r.word     = model_mem[model_head];
          model_head = model_head + 8'd1;
          model_fill = model_fill - 1'b1;
          model_deq  = model_deq + 1'b1;
        end
      end
      OP_STOP: model_stopped = 1'b1;
      OP_QUERY: ;
      default: ;
    endcase
    r.depth      = model_fill;
    r.enq_total  = model_enq;
    r.deq_total  = model_deq;
    r.drop_total = model_drop;
    r.stopped    = model_stopped;
    return r;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t ns: %s mismatch, expected %h actual %h", $time, name, exp_v, act_v);
      errors++;
    end
  endfunction

  // Send one item in bursts with random gaps; predict at the transfer
  task automatic send_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] payload);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, gap_max);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= payload;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    pending_results.push_back(predict_fifo_result(op, payload));
    if (int'(model_fill) > peak_depth) peak_depth = int'(model_fill);
    burst_left--;
    items_sent++;
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic wait_all_results();
    in_tvalid  <= 1'b0;
    burst_left = 0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  // Capacity write, only with nothing in flight
  task automatic write_capacity(input logic [CAP_W-1:0] cap);
    wait_all_results();
    repeat (SETTLE) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= cap;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    model_cap = cap;
    cfg_writes++;
  endtask

  // Result checker
  always @(posedge clk) begin : check_result
    fifo_result_t exp_r;
    if (rst_n && out_tvalid && out_tready) begin
      if (pending_results.size() == 0) begin
        $display("%0t ns: result with no expectation, expected none actual %h",
                 $time, out_tdata);
        errors++;
      end else begin
        exp_r = pending_results.pop_front();
        check_field("status",         64'(exp_r.status),     64'(out_tuser));
        check_field("data_out",       exp_r.word,            out_tdata[63:0]);
        check_field("dropped",        64'(exp_r.dropped),    64'(out_tdata[64]));
        check_field("depth",          64'(exp_r.depth),      64'(out_tdata[73:65]));
        check_field("enqueued_total", exp_r.enq_total,       out_tdata[137:74]);
        check_field("dequeued_total", exp_r.deq_total,       out_tdata[201:138]);
        check_field("dropped_total",  exp_r.drop_total,      out_tdata[265:202]);
        check_field("is_stopped",     64'(exp_r.stopped),    64'(out_tdata[266]));
        check_field("tdata padding",  64'(0),                64'(out_tdata[271:267]));
        results_seen++;
      end
    end
  end

  // Receiver: always ready, random stalls, or occasional long stalls
  always @(posedge clk) begin
    if (stall_left != 0) begin
      out_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else begin
      case (ready_mode)
        0: out_tready <= 1'b1;
        1: out_tready <= ($urandom_range(0, 3) != 0);
        default: begin
          if ($urandom_range(0, 15) == 0) begin
            out_tready <= 1'b0;
            stall_left <= $urandom_range(5, 30);
          end else begin
            out_tready <= 1'b1;
          end
        end
      endcase
    end
  end

  // Watchdog on cycles with no transfer on any channel
  always @(posedge clk) begin
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("%0t ns: no transfer for %0d cycles, %0d results outstanding",
               $time, idle_cycles, pending_results.size());
      $display("** drop_oldest_bounded_fifo_unit: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // Corner cases: empty dequeue, word extremes, capacity 1 and 0, lowered capacity
  task automatic test_directed();
    gap_max    = 3;
    ready_mode = 1;
    send_item(OP_DEQ, '1);
    send_item(OP_QUERY, '1);
    send_item(OP_ENQ, '0);
    send_item(OP_ENQ, '1);
    send_item(OP_ENQ, 64'h5555_5555_5555_5555);
    send_item(OP_ENQ, 64'hAAAA_AAAA_AAAA_AAAA);
    repeat (5) send_item(OP_DEQ, '0);
    write_capacity(9'd1);
    send_item(OP_ENQ, 64'h0123_4567_89AB_CDEF);
    send_item(OP_ENQ, 64'hFEDC_BA98_7654_3210);
    send_item(OP_DEQ, '0);
    write_capacity(9'd0);
    send_item(OP_ENQ, 64'h8000_0000_0000_0001);
    send_item(OP_ENQ, 64'h7FFF_FFFF_FFFF_FFFE);
    send_item(OP_QUERY, '0);
    write_capacity(9'd4);
    repeat (5) send_item(OP_ENQ, {$urandom, $urandom});
    // capacity below depth: depth holds, one drop per enqueue
    write_capacity(9'd2);
    send_item(OP_ENQ, {$urandom, $urandom});
    send_item(OP_DEQ, '0);
    send_item(OP_QUERY, '0);
  endtask

  // Fill to the full store with an oversized capacity, then read a few back
  task automatic test_fill_and_saturate();
    write_capacity(9'd511);
    gap_max    = 0;
    ready_mode = 0;
    repeat (258) send_item(OP_ENQ, {$urandom, $urandom});
    gap_max    = 5;
    ready_mode = 2;
    repeat (6) send_item(OP_DEQ, {$urandom, $urandom});
  endtask

  // Mixed traffic over a range of capacities and idling patterns
  task automatic test_random_traffic();
    logic [CAP_W-1:0] cap;
    logic [OP_W-1:0]  op;
    int               enq_weight;
    int               r;
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: cap = 9'd2;
        1: cap = CAP_W'($urandom_range(3, 16));
        2: cap = 9'd1;
        3: cap = 9'd300;
        4: cap = CAP_W'($urandom_range(0, 511));
        default: cap = 9'd3;
      endcase
      write_capacity(cap);
      gap_max    = ph * 3;
      ready_mode = ph % 3;
      enq_weight = (ph % 2 != 0) ? 40 : 60;
      for (int i = 0; i < 55; i++) begin
        if (ph == 2 && i == 27) wait_all_results();
        r = $urandom_range(0, 99);
        if (r < enq_weight) op = OP_ENQ;
        else if (r < 90) op = OP_DEQ;
        else op = OP_QUERY;
        send_item(op, {$urandom, $urandom});
      end
    end
  endtask

  // Stop latches: refused enqueues, drain, then empty-and-stopped dequeues
  task automatic test_stop_and_drain();
    logic [OP_W-1:0] op;
    int              r;
    write_capacity(CAP_RESET);
    gap_max    = 4;
    ready_mode = 1;
    repeat (6) send_item(OP_ENQ, {$urandom, $urandom});
    send_item(OP_STOP, {$urandom, $urandom});
    repeat (80) begin
      r = $urandom_range(0, 99);
      if (r < 20) op = OP_ENQ;
      else if (r < 70) op = OP_DEQ;
      else if (r < 85) op = OP_STOP;
      else op = OP_QUERY;
      send_item(op, {$urandom, $urandom});
    end
    while (model_fill != 0) send_item(OP_DEQ, {$urandom, $urandom});
    send_item(OP_DEQ, '1);
    send_item(OP_ENQ, '1);
    send_item(OP_STOP, '0);
    send_item(OP_QUERY, '0);
  endtask

  initial begin
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_fill_and_saturate();
    test_random_traffic();
    test_stop_and_drain();
    wait_all_results();
    repeat (10) @(posedge clk);
    $display("Ran %0d items with %0d results checked, %0d capacity writes,",
             items_sent, results_seen, cfg_writes);
    $display("peak depth %0d, %0d overflow drops, queue stopped at the end.",
             peak_depth, model_drop);
    if (errors == 0) begin
      $display("** drop_oldest_bounded_fifo_unit: PASSED **");
    end else begin
      $display("** drop_oldest_bounded_fifo_unit: FAILED **");
    end
    $finish;
  end

endmodule
